FILE: src/mwpo_pkg.sv
// Package: shared types, codes and the quarter-wave sine entry generator.
package mwpo_pkg;

  // Waveform select codes
  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_SAW      = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_mode_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WAVE_MODE   = 2'd0,
    CFG_PHASE_STEP  = 2'd1,
    CFG_PULSE_WIDTH = 2'd2
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_BITS = 2;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // One quarter-wave entry: round(MAX*sin(pi/2*(2k+1)/(2N))), integer Taylor series in Q30.
  // Evaluated at elaboration only (constant arguments).
  function automatic logic [31:0] sine_entry(input int unsigned k,
                                             input int unsigned table_bits,
                                             input int unsigned sample_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] smax;
    logic [63:0] v;
    longint      sum;
    x    = (HALF_PI_Q30 * (64'(2 * k) + 64'd1)) >> (table_bits + 1);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    smax = (64'd1 << (sample_bits - 1)) - 64'd1;
    v    = ((64'(sum) * smax) + (64'd1 << 29)) >> 30;
    if (v > smax) begin
      v = smax;
    end
    return v[31:0];
  endfunction

endpackage

FILE: src/mwpo_req_if.sv
// Request channel: tick or phase-load words into the oscillator.
interface mwpo_req_if #(
  parameter int unsigned PHASE_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [PHASE_BITS-1:0] start_phase;

  modport source (output valid, output req_type, output start_phase, input ready);
  modport sink   (input valid, input req_type, input start_phase, output ready);
endinterface

FILE: src/mwpo_smp_if.sv
// Sample channel: signed waveform words out of the oscillator.
interface mwpo_smp_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: src/multi_waveform_phase_oscillator.sv
// Top level: phase-accumulator oscillator with sine, square, saw and triangle outputs.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+--------------------------------------
//   req      | in  | valid/ready   | req_type, start_phase[PHASE_BITS]
//   smp      | out | valid/ready   | sample[SAMPLE_BITS] signed
//   cfg      | in  | cfg_we_i      | cfg_idx_i[2], cfg_wdata_i[PHASE_BITS]
//
// One word per cycle sustained while smp.ready stays high. A tick registers the sine
// table read and its phase in the table stage; the waveform is then mapped into the
// sample register, from which the sink takes the word. A phase load sets the phase and
// yields no sample. Reset clears the phase and valid flags and sets the configuration
// registers to their defaults; sample and table-stage data are not reset; the table is
// constant. A stalled sample holds its register, the table stage behind it holds, and
// req.ready drops only when both are full and smp.ready is low.
module multi_waveform_phase_oscillator #(
  parameter int unsigned PHASE_BITS      = 24,
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned SAMPLE_BITS     = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mwpo_req_if.sink                          req,
  mwpo_smp_if.source                        smp,
  input  logic                              cfg_we_i,
  input  logic [mwpo_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [PHASE_BITS-1:0]             cfg_wdata_i
);

  localparam int unsigned PB = PHASE_BITS;
  localparam int unsigned TB = SINE_TABLE_BITS;
  localparam int unsigned SB = SAMPLE_BITS;

  localparam logic [PB-1:0] PW_LO    = PB'((64'd1 << PB) / 64'd100);
  localparam logic [PB-1:0] PW_HI    = PB'((64'd99 << PB) / 64'd100);
  localparam logic [PB-1:0] PW_RESET = PB'(64'd1 << (PB - 1));
  localparam logic [PB-1:0] PH_HALF  = PB'(64'd1 << (PB - 1));

  localparam logic signed [SB+1:0] S_MAX  = (SB+2)'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [SB+1:0] S_HALF = (SB+2)'(64'd1 << (SB - 1));

  // Registers and pipeline state
  mwpo_pkg::wave_mode_e  mode_q;
  logic [PB-1:0]         step_q;
  logic [PB-1:0]         pw_q;
  logic [PB-1:0]         pw_d;
  logic [PB-1:0]         phase_q;
  logic                  s1_valid_q;
  logic [PB-1:0]         s1_phase_q;
  logic                  out_valid_q;
  logic signed [SB-1:0]  out_sample_q;
  logic signed [SB-1:0]  sample_d;

  logic                  req_acc;
  logic                  tick_acc;
  logic                  load_acc;
  logic                  out_load;
  logic [TB-1:0]         rom_addr;
  logic [SB-2:0]         rom_data;

  // Handshake
  assign out_load  = s1_valid_q && (!out_valid_q || smp.ready);
  assign req.ready = !s1_valid_q || out_load;
  assign req_acc   = req.valid && req.ready;
  assign tick_acc  = req_acc && !req.req_type;
  assign load_acc  = req_acc && req.req_type;

  // Saturate the pulse width on write
  always_comb begin
    pw_d = cfg_wdata_i;
    if (cfg_wdata_i < PW_LO) begin
      pw_d = PW_LO;
    end else if (cfg_wdata_i > PW_HI) begin
      pw_d = PW_HI;
    end
  end

  // Configuration writes and phase accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= mwpo_pkg::WAVE_SINE;
      step_q  <= '0;
      pw_q    <= PW_RESET;
      phase_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (mwpo_pkg::cfg_idx_e'(cfg_idx_i))
          mwpo_pkg::CFG_WAVE_MODE:   mode_q <= mwpo_pkg::wave_mode_e'(cfg_wdata_i[1:0]);
          mwpo_pkg::CFG_PHASE_STEP:  step_q <= cfg_wdata_i;
          mwpo_pkg::CFG_PULSE_WIDTH: pw_q   <= pw_d;
          default: ;
        endcase
      end
      if (tick_acc) begin
        phase_q <= phase_q + step_q;
      end else if (load_acc) begin
        phase_q <= req.start_phase;
      end
    end
  end

  // Table address: mirror the index in odd quadrants
  always_comb begin
    rom_addr = phase_q[PB-3 -: TB];
    if (phase_q[PB-2]) begin
      rom_addr = ~phase_q[PB-3 -: TB];
    end
  end

  mwpo_sine_rom #(
    .TABLE_BITS  (TB),
    .SAMPLE_BITS (SB)
  ) u_sine_rom (
    .clk_i     (clk_i),
    .rd_en_i   (tick_acc),
    .rd_addr_i (rom_addr),
    .rd_data_o (rom_data)
  );

  // Table stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (tick_acc) begin
      s1_valid_q <= 1'b1;
    end else if (out_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Table stage phase, advanced with the table read
  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_phase_q <= phase_q;
    end
  end

  // Map phase to the selected waveform
  always_comb begin
    logic [PB+SB-1:0]       saw_ext;
    logic [SB-1:0]          saw_u;
    logic [PB-1:0]          tri_d;
    logic [PB+SB:0]         tri_ext;
    logic [SB:0]            tri_t;
    logic signed [SB+1:0]   mag;
    logic signed [SB+1:0]   val;
    saw_ext = '0;
    saw_u   = '0;
    tri_d   = '0;
    tri_ext = '0;
    tri_t   = '0;
    mag     = '0;
    val     = '0;
    case (mode_q)
      mwpo_pkg::WAVE_SINE: begin
        mag = signed'((SB+2)'(rom_data));
        val = s1_phase_q[PB-1] ? -mag : mag;
      end
      mwpo_pkg::WAVE_SQUARE: begin
        val = (s1_phase_q < pw_q) ? S_MAX : -S_MAX;
      end
      mwpo_pkg::WAVE_SAW: begin
        saw_ext = {s1_phase_q, SB'(0)} >> PB;
        saw_u   = saw_ext[SB-1:0];
        val     = signed'((SB+2)'(saw_u)) - S_HALF;
      end
      mwpo_pkg::WAVE_TRIANGLE: begin
        tri_d   = s1_phase_q[PB-1] ? (s1_phase_q - PH_HALF) : (PH_HALF - s1_phase_q);
        tri_ext = {tri_d, (SB+1)'(0)};
        tri_t   = tri_ext[PB+SB -: (SB+1)];
        val     = S_HALF - signed'((SB+2)'(tri_t));
      end
      default: begin
        val = '0;
      end
    endcase
    // Clamp to symmetric full scale
    if (val > S_MAX) begin
      val = S_MAX;
    end else if (val < -S_MAX) begin
      val = -S_MAX;
    end
    sample_d = val[SB-1:0];
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (smp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= sample_d;
    end
  end

  assign smp.valid  = out_valid_q;
  assign smp.sample = out_sample_q;

endmodule

FILE: src/mwpo_sine_rom.sv
// Quarter-wave sine table with a registered read port.
module mwpo_sine_rom #(
  parameter int unsigned TABLE_BITS  = 10,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [TABLE_BITS-1:0]  rd_addr_i,
  output logic [SAMPLE_BITS-2:0] rd_data_o
);

  localparam int unsigned DEPTH = 1 << TABLE_BITS;

  logic [SAMPLE_BITS-2:0] rom_tbl [DEPTH];
  logic [SAMPLE_BITS-2:0] rd_data_q;

  // Fill table contents at elaboration
  for (genvar k = 0; k < DEPTH; k++) begin : g_entry
    assign rom_tbl[k] = (SAMPLE_BITS-1)'(mwpo_pkg::sine_entry(k, TABLE_BITS, SAMPLE_BITS));
  end

  // Register the read word; hold it while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= rom_tbl[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/mwpo_checker.sv
// Port-level checks for the oscillator, bound to the top level.
module mwpo_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   req_valid_i,
  input logic                   req_ready_i,
  input logic                   req_type_i,
  input logic                   smp_valid_i,
  input logic                   smp_ready_i,
  input logic [SAMPLE_BITS-1:0] smp_sample_i
);

  localparam logic [SAMPLE_BITS-1:0] S_MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic tick_acc;
  assign tick_acc = req_valid_i && req_ready_i && !req_type_i;

  // Hold a stalled word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_valid_i && !smp_ready_i |=> smp_valid_i && $stable(smp_sample_i))
    else $error("stalled sample word changed or dropped");

  // Never emit the most negative code
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_valid_i |-> smp_sample_i != S_MOST_NEG)
    else $error("sample outside symmetric full scale");

  // A fresh word comes only from an accepted tick through the table stage
  a_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(smp_valid_i) |-> $past(tick_acc, 2))
    else $error("sample word without a matching tick");

  // Never stall the input while the output is drained
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_ready_i |-> req_ready_i)
    else $error("request stalled while sink is ready");

endmodule

bind multi_waveform_phase_oscillator mwpo_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mwpo_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req.valid),
  .req_ready_i  (req.ready),
  .req_type_i   (req.req_type),
  .smp_valid_i  (smp.valid),
  .smp_ready_i  (smp.ready),
  .smp_sample_i (smp.sample)
);
